// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, the modular multiply beat type, the sequencer state type and the register addresses.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int FB = 31;              // operand width
    localparam int BW = $clog2(FB);      // exponent bit index width

    typedef struct packed {
        logic          vld;
        logic [FB-1:0] acc;
        logic [FB-1:0] a;
        logic [FB-1:0] b;
        logic [FB-1:0] m;
    } mexp_cell_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_SQ,
        S_ML,
        S_DONE
    } mexp_state_t;

    localparam logic ADDR_EXP = 1'b0;
    localparam logic ADDR_MOD = 1'b1;

endpackage

// ===== rtl/mexp_cell.sv =====
// ----------------------------------------------------------------------------
// mexp_cell
// One interleaved shift-add step: acc = (2*acc + b[top]*a) mod m, b moves up.
// ----------------------------------------------------------------------------
module mexp_cell
    import mexp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  mexp_cell_t cell_in,
    output mexp_cell_t cell_out
);

    mexp_cell_t cell_reg, cell_next;
    logic [FB:0] dbl, dred, sum, sred;

    always_comb begin
        dbl  = {cell_in.acc, 1'b0};
        dred = (dbl >= {1'b0, cell_in.m}) ? dbl - {1'b0, cell_in.m} : dbl;
        sum  = cell_in.b[FB-1] ? dred + {1'b0, cell_in.a} : dred;
        sred = (sum >= {1'b0, cell_in.m}) ? sum - {1'b0, cell_in.m} : sum;
        cell_next     = cell_in;
        cell_next.acc = sred[FB-1:0];
        // next cell sees the next lower multiplier bit on top
        cell_next.b   = {cell_in.b[FB-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else begin
            cell_reg.vld <= cell_next.vld;
        end
        cell_reg.acc <= cell_next.acc;
        cell_reg.a   <= cell_next.a;
        cell_reg.b   <= cell_next.b;
        cell_reg.m   <= cell_next.m;
    end

    assign cell_out = cell_reg;

endmodule

// ===== rtl/mexp_mulchain.sv =====
// ----------------------------------------------------------------------------
// mexp_mulchain
// Row of cells computing a*b mod m, one multiplier bit per cell, top bit first.
// ----------------------------------------------------------------------------
module mexp_mulchain
    import mexp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  mexp_cell_t chain_in,
    output mexp_cell_t chain_out
);

    mexp_cell_t link [FB+1];

    assign link[0] = chain_in;

    for (genvar i = 0; i < FB; i++) begin : g_cell
        mexp_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cell_in (link[i]),
            .cell_out(link[i+1])
        );
    end

    assign chain_out = link[FB];

endmodule

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// Sequence: one reduce, then per exponent bit a square and, for a set bit, a
// multiply; each modular product runs through the 31-cell chain.
// Zero exponent or modulus <= 1 skip the products and go straight to the result.
// One item at a time: the next input beat is taken once the result loads.
// Reset (synchronous, aresetn low): exponent 0, modulus 1, channels empty.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] base_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] power_result
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mexp_state_t   state_reg, state_next;
    logic [FB-1:0] exp_reg, mod_reg;
    logic [FB-1:0] base_reg, base_next, acc_reg, acc_next, res_reg, res_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic          busy_reg, busy_next, out_vld_reg, out_vld_next;
    logic [FB-1:0] out_data_reg;
    mexp_cell_t    chain_in, chain_out;
    logic          in_beat, launch, last_bit, out_free;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_EXP) ? {1'b0, exp_reg} : {1'b0, mod_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg <= '0;
            mod_reg <= FB'(1);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ADDR_EXP) begin
                exp_reg <= pwdata[FB-1:0];
            end else begin
                mod_reg <= pwdata[FB-1:0];
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign last_bit = (bit_reg == '0);
    assign out_free = !out_vld_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    state_next = (exp_reg == '0 || mod_reg <= FB'(1)) ? S_DONE : S_RED;
                end
            end
            S_RED: begin
                if (chain_out.vld) state_next = S_SQ;
            end
            S_SQ: begin
                if (chain_out.vld) begin
                    if (exp_reg[bit_reg])  state_next = S_ML;
                    else if (last_bit)     state_next = S_DONE;
                end
            end
            S_ML: begin
                if (chain_out.vld) state_next = last_bit ? S_DONE : S_SQ;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        launch    = 1'b0;
        busy_next = busy_reg;
        base_next = base_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        chain_in.a = acc_reg;
        chain_in.b = acc_reg;
        chain_in.m = mod_reg;
        chain_in.acc = '0;
        case (state_reg)
            S_IDLE: begin
                base_next = s_tdata[FB-1:0];
                res_next  = (exp_reg == '0) ? FB'(1) : '0;
            end
            S_RED: begin
                chain_in.a = FB'(1);
                chain_in.b = base_reg;
                launch = !busy_reg;
                if (chain_out.vld) begin
                    base_next = chain_out.acc;
                    acc_next  = FB'(1);
                    bit_next  = BW'(FB-1);
                end
            end
            S_SQ: begin
                launch = !busy_reg;
                if (chain_out.vld) begin
                    acc_next = chain_out.acc;
                    res_next = chain_out.acc;
                    if (!exp_reg[bit_reg] && !last_bit) bit_next = bit_reg - 1'b1;
                end
            end
            S_ML: begin
                chain_in.a = base_reg;
                launch = !busy_reg;
                if (chain_out.vld) begin
                    acc_next = chain_out.acc;
                    res_next = chain_out.acc;
                    if (!last_bit) bit_next = bit_reg - 1'b1;
                end
            end
            default: ;
        endcase
        if (launch)        busy_next = 1'b1;
        if (chain_out.vld) busy_next = 1'b0;
        chain_in.vld = launch;
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (out_vld_reg && m_tready) out_vld_next = 1'b0;
        if (state_reg == S_DONE && out_free) out_vld_next = 1'b1;
    end

    mexp_mulchain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .chain_in (chain_in),
        .chain_out(chain_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            busy_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            out_vld_reg <= out_vld_next;
        end
        base_reg <= base_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        if (state_reg == S_DONE && out_free) out_data_reg <= res_reg;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    a_chain_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_out.vld |-> busy_reg) else $error("product without request");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !busy_reg) else $error("idle with product in flight");
    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> m_tvalid) else $error("result dropped");

endmodule
